/* rtl/sprq_pkg.sv */
// Shared types and constants of the sorted priority queue.
// No dependencies; every other file imports this package.
package sprq_pkg;

    // Queue geometry and field widths
    localparam int DEPTH = 16;
    localparam int KEY_W = 8;
    localparam int TAG_W = 2;
    localparam int ST_W  = 2;
    localparam int OCC_W = 5;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
    localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [ST_W-1:0] STAT_EMPTY = 2'd2;

    // Controller states
    typedef enum logic {
        CTL_IDLE,
        CTL_HOLD
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic            exec;
        logic            do_insert;
        logic            do_remove;
        logic [ST_W-1:0] status;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

/* rtl/sprq_ctrl.sv */
// Controller of the sorted priority queue: handshake FSM and op decode.
// Depends on sprq_pkg.
module sprq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    output logic              m_valid,
    input  logic              m_ready,
    input  sprq_pkg::dp_stat_t dp_stat,
    output sprq_pkg::dp_cmd_t  dp_cmd
);
    import sprq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake and command decode
    always_comb begin
        s_ready    = (state_reg == CTL_IDLE) || m_ready;
        m_valid    = (state_reg == CTL_HOLD);
        accept     = s_valid && s_ready;
        state_next = state_reg;
        dp_cmd     = '0;
        dp_cmd.exec = accept;

        if (s_opcode == OP_INSERT) begin
            dp_cmd.do_insert = accept && !dp_stat.full;
            dp_cmd.status    = dp_stat.full ? STAT_FULL : STAT_OK;
        end else begin
            dp_cmd.do_remove = accept && !dp_stat.empty;
            dp_cmd.status    = dp_stat.empty ? STAT_EMPTY : STAT_OK;
        end

        case (state_reg)
            CTL_IDLE: begin
                if (accept) state_next = CTL_HOLD;
            end
            CTL_HOLD: begin
                if (accept) state_next = CTL_HOLD;
                else if (m_ready) state_next = CTL_IDLE;
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sprq_datapath.sv */
// Datapath of the sorted priority queue: shift-register cells, entry count
// and result register. Depends on sprq_pkg.
module sprq_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sprq_pkg::dp_cmd_t           dp_cmd,
    output sprq_pkg::dp_stat_t          dp_stat,
    input  logic [sprq_pkg::KEY_W-1:0]  new_key,
    input  logic [sprq_pkg::TAG_W-1:0]  new_tag,
    output logic [sprq_pkg::KEY_W-1:0]  popped_key,
    output logic [sprq_pkg::TAG_W-1:0]  popped_tag,
    output logic [sprq_pkg::ST_W-1:0]   status,
    output logic [sprq_pkg::OCC_W-1:0]  occupancy
);
    import sprq_pkg::*;

    logic [KEY_W-1:0] key_reg [DEPTH];
    logic [KEY_W-1:0] key_next [DEPTH];
    logic [TAG_W-1:0] tag_reg [DEPTH];
    logic [TAG_W-1:0] tag_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DEPTH-1:0] ge;

    logic [KEY_W-1:0] popped_key_reg;
    logic [TAG_W-1:0] popped_tag_reg;
    logic [ST_W-1:0]  status_reg;
    logic [OCC_W-1:0] occupancy_reg;

    assign dp_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign dp_stat.empty = (count_reg == '0);

    // Each held cell compares its key with the new key at once
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (CNT_W'(i) < count_reg) && (key_reg[i] >= new_key);
        end
    end

    // Cell next values: insert shifts down below the slot, remove shifts up
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            key_next[i] = key_reg[i];
            tag_next[i] = tag_reg[i];
        end
        count_next = count_reg;
        if (dp_cmd.do_insert) begin
            if (!ge[0]) begin
                key_next[0] = new_key;
                tag_next[0] = new_tag;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (!ge[i]) begin
                    key_next[i] = ge[i-1] ? new_key : key_reg[i-1];
                    tag_next[i] = ge[i-1] ? new_tag : tag_reg[i-1];
                end
            end
            count_next = count_reg + 1'b1;
        end else if (dp_cmd.do_remove) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                key_next[i] = key_reg[i+1];
                tag_next[i] = tag_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    // Cells hold payload only
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            key_reg[i] <= key_next[i];
            tag_reg[i] <= tag_next[i];
        end
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register, loaded when an item is taken
    always_ff @(posedge aclk) begin
        if (dp_cmd.exec) begin
            popped_key_reg <= dp_cmd.do_remove ? key_reg[0] : '0;
            popped_tag_reg <= dp_cmd.do_remove ? tag_reg[0] : '0;
            status_reg     <= dp_cmd.status;
            occupancy_reg  <= OCC_W'(count_next);
        end
    end

    assign popped_key = popped_key_reg;
    assign popped_tag = popped_tag_reg;
    assign status     = status_reg;
    assign occupancy  = occupancy_reg;

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: controller plus datapath.
// Depends on sprq_pkg, sprq_ctrl and sprq_datapath.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  s_ (in)  | s_valid / s_ready | s_opcode, s_new_key, s_new_tag
//  m_ (out) | m_valid / m_ready | m_popped_key, m_popped_tag, m_status,
//           |                   | m_occupancy
//
// For every item, insert or remove, all cells compare against the new key
// in parallel and shift in the same edge. The result shows in the output
// register in the cycle after acceptance; a new item is taken in
// the cycle its predecessor's result leaves, so one item per cycle is
// sustained when m_ready is high. A stall on m_ stops s_ready.
// Synchronous reset empties the queue; no clearing pass.
module sorted_priority_queue_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [sprq_pkg::KEY_W-1:0]  s_new_key,
    input  logic [sprq_pkg::TAG_W-1:0]  s_new_tag,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [sprq_pkg::KEY_W-1:0]  m_popped_key,
    output logic [sprq_pkg::TAG_W-1:0]  m_popped_tag,
    output logic [sprq_pkg::ST_W-1:0]   m_status,
    output logic [sprq_pkg::OCC_W-1:0]  m_occupancy
);
    import sprq_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    sprq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    sprq_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .new_key    (s_new_key),
        .new_tag    (s_new_tag),
        .popped_key (m_popped_key),
        .popped_tag (m_popped_tag),
        .status     (m_status),
        .occupancy  (m_occupancy)
    );

endmodule

/* rtl/sprq_checker.sv */
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on sprq_pkg and sorted_priority_queue_unit.
module sprq_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [sprq_pkg::KEY_W-1:0]  m_popped_key,
    input logic [sprq_pkg::TAG_W-1:0]  m_popped_tag,
    input logic [sprq_pkg::ST_W-1:0]   m_status,
    input logic [sprq_pkg::OCC_W-1:0]  m_occupancy
);
    import sprq_pkg::*;

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result stays valid
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Error results carry no entry
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> m_popped_key == '0 && m_popped_tag == '0)
        else $error("error result with entry payload");

    // A remove on empty leaves the queue empty
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_EMPTY) |-> m_occupancy == '0)
        else $error("empty status with nonzero occupancy");

    // Occupancy never exceeds the depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (DEPTH > 31) || (m_occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy above depth");

endmodule

bind sorted_priority_queue_unit sprq_checker u_sprq_checker (.*);
